>>> src/fsd_pkg.sv
// Shared types and constants for the per-source rate flood detector.
package fsd_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;

  localparam int unsigned SRC_W   = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 16;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0]  WINDOW_LENGTH_RESET    = TIME_W'(1000000);
  localparam logic [COUNT_W-1:0] ATTACK_THRESHOLD_RESET = COUNT_W'(100);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  typedef struct packed {
    logic [SRC_W-1:0]  source_address;
    logic [TIME_W-1:0] arrival_time;
  } item_t;

  // Head of the input queue as seen by the engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_word_t;

  typedef struct packed {
    logic [SRC_W-1:0]   source;
    logic [TIME_W-1:0]  window_start;
    logic [COUNT_W-1:0] packet_count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

endpackage

>>> src/fsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/fsd_front.sv
// Front end: accepts packet words and buffers them in a short queue.
module fsd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fsd_pkg::item_t      item_i,
  output logic                full_o,
  input  logic                pop_i,
  output fsd_pkg::queue_word_t head_o
);
  import fsd_pkg::*;

  // power of two, so pointers wrap on their own
  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  item_t           buf_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = buf_q[rd_ptr_q];

endmodule

>>> src/fsd_back.sv
// Back end: scans the source table, inserts or updates an entry, reports.
module fsd_back #(
  parameter int unsigned TableEntries = fsd_pkg::TABLE_ENTRIES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fsd_pkg::queue_word_t         head_i,
  output logic                         pop_o,
  input  logic [fsd_pkg::TIME_W-1:0]   window_length_i,
  input  logic [fsd_pkg::COUNT_W-1:0]  attack_threshold_i,
  output logic                         done_o,
  output logic                         flood_detected_o,
  output logic                         source_tracked_o
);
  import fsd_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = IdxW + 1;

  state_e          state_q, state_d;
  item_t           item_q, item_d;
  logic [CntW-1:0] issue_q, issue_d;   // next entry to read
  logic [CntW-1:0] fill_q, fill_d;     // entries 0..fill-1 are valid
  logic            pend_q, pend_d;     // read data due this cycle
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            done_q, done_d;
  logic            flood_q, flood_d;
  logic            tracked_q, tracked_d;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               hit, table_full;
  logic [TIME_W-1:0]  elapsed;
  logic               in_window;
  logic [COUNT_W-1:0] cnt_inc;

  fsd_ram #(
    .Width (ENTRY_W),
    .Depth (TableEntries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry   = entry_t'(ram_rdata);
  assign hit        = pend_q && (rd_entry.source == item_q.source_address);
  assign table_full = (fill_q == CntW'(TableEntries));
  assign elapsed    = item_q.arrival_time - rd_entry.window_start;
  assign in_window  = (elapsed < window_length_i);
  assign cnt_inc    = (rd_entry.packet_count == COUNT_MAX) ? COUNT_MAX
                                                           : rd_entry.packet_count + COUNT_ONE;

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    issue_d    = issue_q;
    fill_d     = fill_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    hit_idx_d  = hit_idx_q;
    done_d     = 1'b0;
    flood_d    = flood_q;
    tracked_d  = tracked_q;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = hit_idx_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = issue_q[IdxW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          item_d  = head_i.item;
          issue_d = '0;
          state_d = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        if (hit) begin
          hit_idx_d = pend_idx_q;
          state_d   = ST_UPDATE;
        end else if (issue_q != fill_q) begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = issue_q[IdxW-1:0];
          issue_d    = issue_q + CntW'(1);
        end else begin
          // scanned every stored source without a match
          done_d  = 1'b1;
          flood_d = 1'b0;
          state_d = ST_IDLE;
          if (table_full) begin
            tracked_d = 1'b0;
          end else begin
            tracked_d              = 1'b1;
            ram_we                 = 1'b1;
            ram_waddr              = fill_q[IdxW-1:0];
            ram_wdata.source       = item_q.source_address;
            ram_wdata.window_start = item_q.arrival_time;
            ram_wdata.packet_count = COUNT_ONE;
            fill_d                 = fill_q + CntW'(1);
          end
        end
      end

      ST_UPDATE: begin
        ram_we           = 1'b1;
        ram_wdata.source = item_q.source_address;
        done_d           = 1'b1;
        tracked_d        = 1'b1;
        state_d          = ST_IDLE;
        if (in_window) begin
          ram_wdata.window_start = rd_entry.window_start;
          ram_wdata.packet_count = cnt_inc;
          flood_d                = (cnt_inc >= attack_threshold_i);
        end else begin
          ram_wdata.window_start = item_q.arrival_time;
          ram_wdata.packet_count = COUNT_ONE;
          flood_d                = 1'b0;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      issue_q    <= '0;
      fill_q     <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      issue_q    <= issue_d;
      fill_q     <= fill_d;
      pend_q     <= pend_d;
      pend_idx_q <= pend_idx_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    hit_idx_q <= hit_idx_d;
    flood_q   <= flood_d;
    tracked_q <= tracked_d;
  end

  assign done_o           = done_q;
  assign flood_detected_o = flood_q;
  assign source_tracked_o = tracked_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(TableEntries))
    else $error("fill count beyond table size");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q <= fill_q)
    else $error("scan read past valid entries");

  a_pend_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_SEARCH) && (CntW'(pend_idx_q) < fill_q))
    else $error("read data pending outside search or on an invalid entry");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("two results in consecutive cycles");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> $past(done_d) && !$past(flood_d) && $past(tracked_d))
    else $error("table grew without an insert result");
`endif

endmodule

>>> src/per_source_rate_flood_detector.sv
// Top level of the per-source rate flood detector: config registers, front, back.
//
// A packet word (source_address_i, arrival_time_i) is taken at a rising edge where
// start is high and busy is low; busy rises only when the two-word input queue is
// full. Each packet yields exactly one result on flood_detected_o/source_tracked_o,
// shown for one cycle with done_o high; the receiver cannot stall, so results must
// be captured when done_o is seen. Results come out in packet order. The back end
// scans a single-write, single-read entry RAM one entry per cycle, so a packet
// occupies it longer the higher the entry k that holds its source; a source not
// stored costs a scan of all n sources held. The queue lets new packets arrive
// meanwhile. Sources fill the table from entry 0 and are never evicted, so a fill
// count marks the valid entries and no clearing pass runs after reset. Once the
// table is full, new sources get source_tracked_o low. Config writes (index 0:
// window length, index 1: attack threshold, others ignored) are always accepted
// and should be made only while no packet is in flight.
module per_source_rate_flood_detector #(
  parameter int unsigned TableEntries = fsd_pkg::TABLE_ENTRIES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // packet words
  input  logic                           start,
  output logic                           busy,
  input  logic [fsd_pkg::SRC_W-1:0]      source_address_i,
  input  logic [fsd_pkg::TIME_W-1:0]     arrival_time_i,
  // results
  output logic                           done_o,
  output logic                           flood_detected_o,
  output logic                           source_tracked_o,
  // config writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fsd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fsd_pkg::*;

  logic [TIME_W-1:0]  window_length_q;
  logic [COUNT_W-1:0] attack_threshold_q;
  logic               cfg_write;

  item_t       in_item;
  queue_word_t head;
  logic        pop;

  // config port never back-pressures
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q    <= WINDOW_LENGTH_RESET;
      attack_threshold_q <= ATTACK_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_WINDOW_LENGTH:    window_length_q    <= cfg_data_i[TIME_W-1:0];
        CFG_ATTACK_THRESHOLD: attack_threshold_q <= cfg_data_i[COUNT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign in_item.source_address = source_address_i;
  assign in_item.arrival_time   = arrival_time_i;

  fsd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (start),
    .item_i (in_item),
    .full_o (busy),
    .pop_i  (pop),
    .head_o (head)
  );

  fsd_back #(
    .TableEntries (TableEntries)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .pop_o              (pop),
    .window_length_i    (window_length_q),
    .attack_threshold_i (attack_threshold_q),
    .done_o             (done_o),
    .flood_detected_o   (flood_detected_o),
    .source_tracked_o   (source_tracked_o)
  );

endmodule

>>> tb/sv/per_source_rate_flood_detector_test.sv
// Self-checking testbench for the per-source rate flood detector.
module per_source_rate_flood_detector_test;
  import fsd_pkg::*;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_ATTACK_THRESHOLD + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = '1;

  localparam int unsigned HOT_SOURCES        = 8;      // busy talkers, so counts climb
  localparam int unsigned WORDS_PER_SETTING  = 130;
  localparam int unsigned MAX_REPORTS        = 20;

  typedef struct packed {
    logic flood;
    logic tracked;
  } verdict_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [SRC_W-1:0]      source_address_i;
  logic [TIME_W-1:0]     arrival_time_i;
  logic                  done_o;
  logic                  flood_detected_o;
  logic                  source_tracked_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  per_source_rate_flood_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .source_address_i (source_address_i),
    .arrival_time_i   (arrival_time_i),
    .done_o           (done_o),
    .flood_detected_o (flood_detected_o),
    .source_tracked_o (source_tracked_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Our own copy of the source table and the two registers.
  logic               tbl_valid  [TABLE_ENTRIES];
  logic [SRC_W-1:0]   tbl_source [TABLE_ENTRIES];
  logic [TIME_W-1:0]  tbl_start  [TABLE_ENTRIES];
  logic [COUNT_W-1:0] tbl_count  [TABLE_ENTRIES];
  int unsigned        sources_held;
  logic [TIME_W-1:0]  cur_window;
  logic [COUNT_W-1:0] cur_threshold;

  verdict_t    pending_verdicts[$];  // one per accepted word, oldest first
  int unsigned gap_pct;              // chance in percent that the sender idles a cycle
  int unsigned mismatches;
  int unsigned packets_sent;
  int unsigned results_seen;
  int unsigned floods_seen;
  int unsigned untracked_seen;
  int unsigned config_writes;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Looks the source up, updates the table and returns the verdict for this word.
  function automatic verdict_t classify_packet(input logic [SRC_W-1:0] src,
                                               input logic [TIME_W-1:0] now);
    verdict_t          v;
    int                slot;
    logic [TIME_W-1:0] elapsed;
    v.flood   = 1'b0;
    v.tracked = 1'b1;
    slot      = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot < 0 && tbl_valid[i] && tbl_source[i] == src) slot = i;
    if (slot < 0) begin
      // unknown source: take the lowest free entry, if any
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (slot < 0 && !tbl_valid[i]) slot = i;
      if (slot < 0) begin
        v.tracked = 1'b0;
      end else begin
        tbl_valid[slot]  = 1'b1;
        tbl_source[slot] = src;
        tbl_start[slot]  = now;
        tbl_count[slot]  = COUNT_ONE;
        sources_held++;
      end
    end else begin
      elapsed = now - tbl_start[slot];  // wraps mod 2^32
      if (elapsed < cur_window) begin
        if (tbl_count[slot] != COUNT_MAX) tbl_count[slot] = tbl_count[slot] + 1'b1;
        v.flood = (tbl_count[slot] >= cur_threshold);
      end else begin
        // window ran out: restart it here
        tbl_start[slot] = now;
        tbl_count[slot] = COUNT_ONE;
      end
    end
    return v;
  endfunction

  // Offers one packet word; leaves start high so a back-to-back word needs no toggle.
  task automatic send_packet(input logic [SRC_W-1:0] src, input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start            <= 1'b1;
    source_address_i <= src;
    arrival_time_i   <= now;
    do @(posedge clk_i); while (busy);
    pending_verdicts.push_back(classify_packet(src, now));
    packets_sent++;
  endtask

  // Stop offering words and wait for every pending result.
  task automatic drain();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Register write; keep_valid leaves valid up for a following write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data, input bit keep_valid);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_WINDOW_LENGTH) cur_window = data;
    else if (idx == CFG_ATTACK_THRESHOLD) cur_threshold = data[COUNT_W-1:0];
    config_writes++;
    if (!keep_valid) cfg_valid_i <= 1'b0;
  endtask

  // Threshold upper bits are random: only the low 16 bits count.
  task automatic configure(input logic [TIME_W-1:0] window, input logic [COUNT_W-1:0] thresh);
    drain();
    write_register(CFG_WINDOW_LENGTH, window, 1'b1);
    write_register(CFG_ATTACK_THRESHOLD, {(CFG_DATA_W-COUNT_W)'($urandom), thresh}, 1'b0);
  endtask

  // Address and time extremes, window edges, wrap, threshold hit, zero settings, ignored indexes.
  task automatic test_edge_cases();
    // reset settings: 1000000-tick window, threshold 100
    send_packet(32'h0000_0000, 32'd0);
    send_packet(32'h0000_0000, 32'd999_999);      // last open tick
    send_packet(32'h0000_0000, 32'd1_000_000);    // first closed tick: restart
    send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_packet(32'hFFFF_FFFF, 32'h0000_0004);    // time wrapped, still in window
    configure(32'd10, 16'd3);
    send_packet(32'hFFFF_FFFF, 32'd14);           // expired, restart at 14
    send_packet(32'hFFFF_FFFF, 32'd23);           // elapsed 9, count 2
    send_packet(32'hFFFF_FFFF, 32'd23);           // count 3: flood
    send_packet(32'hFFFF_FFFF, 32'd23);           // count 4: flood
    send_packet(32'hFFFF_FFFF, 32'd24);           // elapsed 10: restart
    send_packet(32'h8000_0000, 32'h7FFF_FFFF);
    send_packet(32'h5555_5555, 32'h0000_1000);
    send_packet(32'hAAAA_AAAA, 32'h0000_2000);
    configure(32'd10, 16'd1);
    send_packet(32'hAAAA_AAAA, 32'h0000_2000);    // count 2 over threshold 1
    configure(32'd0, 16'd0);
    send_packet(32'h5555_5555, 32'h0000_1000);    // zero window: always restart
    configure('1, 16'd0);
    send_packet(32'h5555_5555, 32'h0000_1000);    // zero threshold: flood at once
    drain();
    write_register(CFG_UNUSED_FIRST, '1, 1'b1);   // both ignored
    write_register(CFG_UNUSED_LAST, '0, 1'b0);
    send_packet(32'h5555_5555, 32'h0000_1001);
    send_packet(32'h8000_0000, 32'h7FFF_FFFE);    // elapsed all ones == window: restart
  endtask

  // Fill every entry, then new sources must come back untracked and held ones tracked.
  task automatic test_table_full();
    configure($urandom_range(100000, 100), COUNT_W'($urandom_range(20, 2)));
    while (sources_held < TABLE_ENTRIES) send_packet($urandom, $urandom);
    repeat (4) send_packet($urandom, $urandom);
    repeat (4) send_packet(tbl_source[$urandom_range(TABLE_ENTRIES - 1)], $urandom);
  endtask

  // Bulk traffic: mostly known sources timed around their window edges, some strangers.
  task automatic test_rate_windows();
    int unsigned       phase_gap [3] = '{27, 86, 0};
    int unsigned       roll;
    int                slot;
    logic [SRC_W-1:0]  src;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] offset;
    for (int p = 0; p < 3; p++) begin
      gap_pct = phase_gap[p];
      for (int s = 0; s < 4; s++) begin
        case (s)
          0: configure($urandom_range(16, 1), COUNT_W'($urandom_range(4, 1)));
          1: configure($urandom_range(5000, 17), COUNT_W'($urandom_range(10, 2)));
          2: configure(32'd1, 16'd1);
          default: configure('1, COUNT_MAX);
        endcase
        repeat (WORDS_PER_SETTING) begin
          roll = $urandom_range(99);
          if (roll < 15) begin
            src = $urandom;
            now = $urandom;
          end else begin
            slot = ($urandom_range(99) < 70) ? $urandom_range(HOT_SOURCES - 1)
                                               : $urandom_range(sources_held - 1);
            src  = tbl_source[slot];
            roll = $urandom_range(99);
            if (roll < 60) offset = $urandom_range(cur_window - 1, 0);
            else if (roll < 80) offset = cur_window - roll[0];  // straddle the edge
            else offset = $urandom;
            now = tbl_start[slot] + offset;
          end
          send_packet(src, now);
        end
      end
    end
  endtask

  // Each result comes with done_o high; compare against the oldest verdict.
  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (flood_detected_o === 1'b1) floods_seen++;
      if (source_tracked_o === 1'b0) untracked_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result %0d with no packet pending", results_seen));
      end else begin
        want = pending_verdicts.pop_front();
        if (flood_detected_o !== want.flood)
          report_mismatch($sformatf("result %0d: flood_detected %b, expected %b",
                                    results_seen, flood_detected_o, want.flood));
        if (source_tracked_o !== want.tracked)
          report_mismatch($sformatf("result %0d: source_tracked %b, expected %b",
                                    results_seen, source_tracked_o, want.tracked));
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    source_address_i = '0;
    arrival_time_i   = '0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
    sources_held  = 0;
    cur_window    = WINDOW_LENGTH_RESET;
    cur_threshold = ATTACK_THRESHOLD_RESET;
    gap_pct       = 27;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_edge_cases();
    test_table_full();
    test_rate_windows();

    // let any stray result show up before closing
    drain();
    repeat (TABLE_ENTRIES + 8) @(posedge clk_i);
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));

    $display("Covered %0d packets over %0d register writes: %0d floods, %0d untracked.",
             packets_sent, config_writes, floods_seen, untracked_seen);
    $display("Included table fill, window edges and wrap, zero settings, ignored indexes.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
